// File: src/smra_pkg.sv
// ----------------------------------------------------------------------------
// Sign-magnitude register ALU package
// Item types, opcode and status codes and sizing constants shared by the
// register ALU and the projects that drive it.
// ----------------------------------------------------------------------------
package smra_pkg;

	// Register file sizing.
	localparam int NUM_REGS_DEF = 16;
	localparam int MAG_W        = 16;
	localparam int OP_W         = 8;
	localparam int REG_IDX_W    = 8;
	localparam int STATUS_W     = 2;

	// Opcodes.
	localparam logic [OP_W-1:0] OPC_DIV  = 8'd128;
	localparam logic [OP_W-1:0] OPC_MUL  = 8'd129;
	localparam logic [OP_W-1:0] OPC_ADD  = 8'd130;
	localparam logic [OP_W-1:0] OPC_SUB  = 8'd131;
	localparam logic [OP_W-1:0] OPC_MOV  = 8'd132;
	localparam logic [OP_W-1:0] OPC_DEC  = 8'd192;
	localparam logic [OP_W-1:0] OPC_INC  = 8'd193;
	localparam logic [OP_W-1:0] OPC_SSGN = 8'd194;
	localparam logic [OP_W-1:0] OPC_ISGN = 8'd195;
	localparam logic [OP_W-1:0] OPC_AND  = 8'd1;
	localparam logic [OP_W-1:0] OPC_OR   = 8'd2;
	localparam logic [OP_W-1:0] OPC_XOR  = 8'd3;
	localparam logic [OP_W-1:0] OPC_NOT  = 8'd68;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADREG  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd3;

	// One decoded instruction.
	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic                 first_sign_bit;
		logic                 second_is_value;
		logic                 second_sign_bit;
		logic [REG_IDX_W-1:0] dest_reg;
		logic [MAG_W-1:0]     second_field;
		logic                 end_of_run;
	} instr_t;

	// One result item.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [MAG_W-1:0]    dest_value;
		logic                dest_positive;
		logic [MAG_W-1:0]    zero_value;
		logic                zero_positive;
		logic                run_done;
	} result_t;

	// One register: positive flag above the magnitude.
	typedef struct packed {
		logic             positive;
		logic [MAG_W-1:0] mag;
	} reg_entry_t;

endpackage

// File: src/sign_magnitude_register_alu_unit.sv
// ----------------------------------------------------------------------------
// Sign-magnitude register ALU
// Executes one decoded instruction per item on a file of sign-magnitude
// registers, with a shared iterative add/subtract unit for MUL and DIV.
// ----------------------------------------------------------------------------
// Usage:
// An instruction item is taken on cmd at a rising edge where start is high
// and busy is low. Exactly one result item follows on result, valid for the
// single cycle in which strobe is high; the receiver cannot stall it.
// The register file is a two-read, one-write memory with registered reads;
// an item passes through the read state, the operand state and, for MUL
// and for DIV by a nonzero divisor, the sixteen-step multiply/divide loop;
// a bad register index skips straight to the write-back state. A new item
// may be accepted in the strobe cycle; no new item is taken while busy.
// Reset clears every register to positive zero at once by per-register
// valid bits; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module sign_magnitude_register_alu_unit #(
	parameter int NUM_REGS = smra_pkg::NUM_REGS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  smra_pkg::instr_t  cmd,
	output logic              strobe,
	output smra_pkg::result_t result
);
	import smra_pkg::*;

	localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int CNT_W = $clog2(MAG_W);

	// Sequencer codes.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_ITER = 3'd3;
	localparam logic [2:0] S_WB   = 3'd4;

	logic [2:0]          state_q;
	instr_t              cmd_q;
	logic [STATUS_W-1:0] status_q;
	logic                we_q;
	logic                div_q;
	logic                pos_q;
	logic [MAG_W-1:0]    acc_q;
	logic [MAG_W-1:0]    x_q;
	logic [MAG_W-1:0]    y_q;
	logic [CNT_W-1:0]    cnt_q;
	reg_entry_t          zero_q;
	logic [NUM_REGS-1:0] valid_q;
	reg_entry_t          rd_d_q;
	reg_entry_t          rd_s_q;
	logic                vd_q;
	logic                vs_q;
	logic                strobe_q;
	result_t             result_q;

	reg_entry_t          mem [NUM_REGS];

	logic                accept;
	logic                bad_idx;
	logic [IDX_W-1:0]    d_addr;
	logic [IDX_W-1:0]    s_addr;
	reg_entry_t          op_d;
	reg_entry_t          op_s;
	logic [MAG_W-1:0]    a;
	logic [MAG_W-1:0]    b;
	logic                sa;
	logic                sb;
	logic                sb_eff;
	logic [MAG_W-1:0]    simple_mag;
	logic                simple_pos;
	logic                simple_we;
	logic [STATUS_W-1:0] simple_status;
	logic [MAG_W:0]      opa;
	logic [MAG_W:0]      opb;
	logic                alu_sub;
	logic [MAG_W+1:0]    alu_sum;
	logic                div_ge;
	logic [MAG_W-1:0]    final_mag;
	reg_entry_t          final_entry;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign strobe = strobe_q;
	assign result = result_q;

	// Index check on the incoming item, before any opcode is looked at.
	assign bad_idx = ({1'b0, cmd.dest_reg} >= (REG_IDX_W+1)'(NUM_REGS)) ||
		(!cmd.second_is_value && ({1'b0, cmd.second_field} >= (MAG_W+1)'(NUM_REGS)));

	assign d_addr = cmd_q.dest_reg[IDX_W-1:0];
	assign s_addr = cmd_q.second_field[IDX_W-1:0];

	// Operands; a register never written reads as positive zero.
	always_comb begin
		op_d = vd_q ? rd_d_q : reg_entry_t'{positive: 1'b1, mag: '0};
		op_s = vs_q ? rd_s_q : reg_entry_t'{positive: 1'b1, mag: '0};
		a    = op_d.mag;
		sa   = op_d.positive;
		if (cmd_q.second_is_value) begin
			b  = cmd_q.second_field;
			sb = cmd_q.second_sign_bit;
		end else begin
			b  = op_s.mag;
			sb = op_s.positive;
		end
	end

	// Combinational opcodes; DIV and MUL only seed the loop here.
	always_comb begin
		sb_eff        = (cmd_q.op == OPC_SUB) ? !sb : sb;
		simple_mag    = a;
		simple_pos    = sa;
		simple_we     = 1'b1;
		simple_status = ST_OK;
		unique case (cmd_q.op)
			OPC_ADD, OPC_SUB: begin
				if (sa == sb_eff) begin
					simple_mag = a + b;
				end else begin
					simple_mag = (a >= b) ? (a - b) : (b - a);
					if (a < b) begin
						simple_pos = sb_eff;
					end
				end
			end
			OPC_MOV: begin
				simple_mag = b;
				simple_pos = sb;
			end
			OPC_DEC: begin
				if (a == '0) begin
					simple_mag = MAG_W'(1);
					simple_pos = 1'b0;
				end else begin
					simple_mag = sa ? (a - MAG_W'(1)) : (a + MAG_W'(1));
				end
			end
			OPC_INC: begin
				if (a == '0) begin
					simple_mag = MAG_W'(1);
					simple_pos = 1'b1;
				end else begin
					simple_mag = sa ? (a + MAG_W'(1)) : (a - MAG_W'(1));
				end
			end
			OPC_SSGN: simple_pos = cmd_q.first_sign_bit;
			OPC_ISGN: simple_pos = !sa;
			OPC_AND: begin
				simple_mag = a & b;
				simple_pos = sa && sb;
			end
			OPC_OR: begin
				simple_mag = a | b;
				simple_pos = sa || sb;
			end
			OPC_XOR: begin
				simple_mag = a ^ b;
				simple_pos = (sa != sb);
			end
			OPC_NOT: begin
				simple_mag = ~a;
				simple_pos = !sa;
			end
			OPC_DIV, OPC_MUL: begin
				simple_pos = (sa == sb);
			end
			default: begin
				simple_we     = 1'b0;
				simple_status = ST_UNKNOWN;
			end
		endcase
	end

	// Shared adder: a shift-add step for MUL, a restoring step for DIV.
	always_comb begin
		if (div_q) begin
			opa     = {acc_q, x_q[MAG_W-1]};
			opb     = {1'b0, y_q};
			alu_sub = 1'b1;
		end else begin
			opa     = {1'b0, acc_q};
			opb     = {1'b0, (y_q[0] ? x_q : {MAG_W{1'b0}})};
			alu_sub = 1'b0;
		end
		alu_sum = alu_sub ? ({1'b0, opa} - {1'b0, opb}) : ({1'b0, opa} + {1'b0, opb});
		div_ge  = !alu_sum[MAG_W+1];
	end

	// Value written back and reported.
	assign final_mag   = div_q ? x_q : acc_q;
	assign final_entry = '{positive: pos_q, mag: final_mag};

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
			valid_q  <= '0;
			zero_q   <= '{positive: 1'b1, mag: '0};
		end else begin
			strobe_q <= (state_q == S_WB);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= bad_idx ? S_WB : S_READ;
					end
				end
				S_READ: state_q <= S_LOAD;
				S_LOAD: begin
					if ((cmd_q.op == OPC_MUL) ||
						((cmd_q.op == OPC_DIV) && (b != '0))) begin
						state_q <= S_ITER;
					end else begin
						state_q <= S_WB;
					end
				end
				S_ITER: begin
					if (cnt_q == CNT_W'(MAG_W-1)) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					state_q <= S_IDLE;
					if (we_q) begin
						valid_q[d_addr] <= 1'b1;
						if (d_addr == '0) begin
							zero_q <= final_entry;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q    <= cmd;
					status_q <= bad_idx ? ST_BADREG : ST_OK;
					we_q     <= 1'b0;
					div_q    <= 1'b0;
					pos_q    <= 1'b0;
					acc_q    <= '0;
				end
			end
			S_LOAD: begin
				cnt_q <= '0;
				x_q   <= a;
				y_q   <= b;
				if (cmd_q.op == OPC_DIV) begin
					if (b == '0) begin
						status_q <= ST_DIVZERO;
						we_q     <= 1'b0;
						div_q    <= 1'b0;
						acc_q    <= a;
						pos_q    <= sa;
					end else begin
						status_q <= ST_OK;
						we_q     <= 1'b1;
						div_q    <= 1'b1;
						acc_q    <= '0;
						pos_q    <= simple_pos;
					end
				end else if (cmd_q.op == OPC_MUL) begin
					status_q <= ST_OK;
					we_q     <= 1'b1;
					div_q    <= 1'b0;
					acc_q    <= '0;
					pos_q    <= simple_pos;
				end else begin
					status_q <= simple_status;
					we_q     <= simple_we;
					div_q    <= 1'b0;
					acc_q    <= simple_mag;
					pos_q    <= simple_pos;
				end
			end
			S_ITER: begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (div_q) begin
					acc_q <= div_ge ? alu_sum[MAG_W-1:0] : opa[MAG_W-1:0];
					x_q   <= {x_q[MAG_W-2:0], div_ge};
				end else begin
					acc_q <= alu_sum[MAG_W-1:0];
					x_q   <= {x_q[MAG_W-2:0], 1'b0};
					y_q   <= {1'b0, y_q[MAG_W-1:1]};
				end
			end
			S_WB: begin
				result_q.status        <= status_q;
				result_q.dest_value    <= final_entry.mag;
				result_q.dest_positive <= final_entry.positive;
				result_q.run_done      <= cmd_q.end_of_run;
				if (we_q && (d_addr == '0)) begin
					result_q.zero_value    <= final_entry.mag;
					result_q.zero_positive <= final_entry.positive;
				end else begin
					result_q.zero_value    <= zero_q.mag;
					result_q.zero_positive <= zero_q.positive;
				end
			end
			default: begin
			end
		endcase
	end

	// Register file: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if ((state_q == S_WB) && we_q) begin
			mem[d_addr] <= final_entry;
		end
		rd_d_q <= mem[d_addr];
		rd_s_q <= mem[s_addr];
		vd_q   <= valid_q[d_addr];
		vs_q   <= valid_q[s_addr];
	end

	// The block reports ready again in the cycle of its result.
	assert property (@(posedge clk) disable iff (!arst_n) strobe |-> !busy)
		else $error("result strobe while busy");

	// An accepted item always makes the block busy.
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy)
		else $error("accepted item did not start the sequencer");

	// A bad index reports a cleared destination.
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (result.status == ST_BADREG)) |->
		((result.dest_value == '0) && !result.dest_positive))
		else $error("bad index result carries a destination value");

	// Nothing is written back for a failed instruction.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_WB) && (status_q != ST_OK)) |-> !we_q)
		else $error("failed instruction would write the register file");

endmodule

// File: verif/sign_magnitude_register_alu_unit_tb.sv
// ----------------------------------------------------------------------------
// Sign-magnitude register ALU testbench
// Drives instruction items into the register ALU from a queue of pending
// items, predicts every result with a behavioural copy of the register file,
// and checks each strobed result against the oldest prediction. Directed
// items come first, then randomised traffic with bursty start timing.
// ----------------------------------------------------------------------------
module sign_magnitude_register_alu_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smra_pkg::*;

	localparam int NUM_REGS       = NUM_REGS_DEF;
	localparam int SH_IDX_W       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int RANDOM_ITEMS   = 450;
	localparam int RESET_CYCLES   = 12;
	localparam int TAIL_CYCLES    = 24;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTS    = 10;

	localparam logic [OP_W-1:0] OP_LIST [0:12] = '{
		OPC_DIV, OPC_MUL, OPC_ADD, OPC_SUB, OPC_MOV, OPC_DEC, OPC_INC,
		OPC_SSGN, OPC_ISGN, OPC_AND, OPC_OR, OPC_XOR, OPC_NOT
	};

	// An item waiting to be sent; drain_first holds it back until the block
	// has returned every outstanding result.
	typedef struct {
		instr_t cmd;
		bit     drain_first;
	} pending_item_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	instr_t  cmd = '0;
	logic    busy;
	logic    strobe;
	result_t result;

	pending_item_t pending_items[$];
	result_t       predicted_results[$];

	// Shadow copy of the register file.
	logic [MAG_W-1:0] shadow_mag [NUM_REGS];
	logic             shadow_pos [NUM_REGS];

	int mismatches  = 0;
	int idle_cycles = 0;
	int gap_left    = 0;
	int burst_left  = 1;

	sign_magnitude_register_alu_unit #(
		.NUM_REGS(NUM_REGS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.strobe(strobe),
		.result(result)
	);

	// Free-running clock, 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Executes one instruction on the shadow register file and returns the
	// result item that the block should produce for it.
	function automatic result_t alu_execute(instr_t c);
		result_t          r;
		logic [MAG_W-1:0] a, b, m;
		logic             sa, sb, sbe, s;
		logic [STATUS_W-1:0] st;
		logic [SH_IDX_W-1:0] di, si;
		r = '0;
		r.zero_value    = shadow_mag[0];
		r.zero_positive = shadow_pos[0];
		r.run_done      = c.end_of_run;
		// Index check comes before the opcode, for every opcode.
		if (c.dest_reg >= NUM_REGS || (!c.second_is_value && c.second_field >= NUM_REGS)) begin
			r.status = ST_BADREG;
			return r;
		end
		di = c.dest_reg[SH_IDX_W-1:0];
		si = c.second_field[SH_IDX_W-1:0];
		a  = shadow_mag[di];
		sa = shadow_pos[di];
		if (c.second_is_value) begin
			b  = c.second_field;
			sb = c.second_sign_bit;
		end else begin
			b  = shadow_mag[si];
			sb = shadow_pos[si];
		end
		m  = a;
		s  = sa;
		st = ST_OK;
		case (c.op)
			OPC_DIV: begin
				if (b == '0) begin
					st = ST_DIVZERO;
				end else begin
					m = a / b;
					s = (sa == sb);
				end
			end
			OPC_MUL: begin
				m = a * b;
				s = (sa == sb);
			end
			OPC_ADD, OPC_SUB: begin
				// Subtraction is addition with the second sign inverted.
				sbe = (c.op == OPC_SUB) ? !sb : sb;
				if (sa == sbe) begin
					m = a + b;
				end else begin
					m = (a >= b) ? a - b : b - a;
					if (a < b)
						s = sbe;
				end
			end
			OPC_MOV: begin
				m = b;
				s = sb;
			end
			OPC_DEC: begin
				if (a == '0) begin
					m = MAG_W'(1);
					s = 1'b0;
				end else begin
					m = sa ? a - 1'b1 : a + 1'b1;
				end
			end
			OPC_INC: begin
				if (a == '0) begin
					m = MAG_W'(1);
					s = 1'b1;
				end else begin
					m = sa ? a + 1'b1 : a - 1'b1;
				end
			end
			OPC_SSGN: s = c.first_sign_bit;
			OPC_ISGN: s = !sa;
			OPC_AND: begin
				m = a & b;
				s = sa & sb;
			end
			OPC_OR: begin
				m = a | b;
				s = sa | sb;
			end
			OPC_XOR: begin
				m = a ^ b;
				s = sa ^ sb;
			end
			OPC_NOT: begin
				m = ~a;
				s = !sa;
			end
			default: st = ST_UNKNOWN;
		endcase
		if (st == ST_OK) begin
			shadow_mag[di] = m;
			shadow_pos[di] = s;
		end
		r.status        = st;
		r.dest_value    = shadow_mag[di];
		r.dest_positive = shadow_pos[di];
		r.zero_value    = shadow_mag[0];
		r.zero_positive = shadow_pos[0];
		return r;
	endfunction

	function automatic instr_t make_instr(logic [OP_W-1:0] op, logic first_sign,
			logic is_value, logic second_sign, logic [REG_IDX_W-1:0] dest,
			logic [MAG_W-1:0] field, logic last);
		instr_t c;
		c.op              = op;
		c.first_sign_bit  = first_sign;
		c.second_is_value = is_value;
		c.second_sign_bit = second_sign;
		c.dest_reg        = dest;
		c.second_field    = field;
		c.end_of_run      = last;
		return c;
	endfunction

	task automatic queue_item(instr_t c, bit drain_first);
		pending_item_t p;
		p.cmd         = c;
		p.drain_first = drain_first;
		pending_items.push_back(p);
	endtask

	// Driver: predicts each accepted item, then offers the next pending item
	// in bursts separated by random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				predicted_results.push_back(alu_execute(cmd));
			if (!start || !busy) begin
				if (gap_left != 0) begin
					start    <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_items.size() == 0) begin
					start <= 1'b0;
				end else if (pending_items[0].drain_first &&
						(predicted_results.size() != 0 || strobe)) begin
					start <= 1'b0;
				end else begin
					cmd   <= pending_items[0].cmd;
					start <= 1'b1;
					pending_items.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						case ($urandom_range(0, 9))
							0, 1, 2: gap_left <= 0;
							3, 4, 5, 6, 7: gap_left <= $urandom_range(1, 6);
							default: gap_left <= $urandom_range(7, 30);
						endcase
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// Monitor: every strobed result is checked against the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (predicted_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result item: status %0d dest %0d/%0b zero %0d/%0b done %0b",
						result.status, result.dest_value, result.dest_positive,
						result.zero_value, result.zero_positive, result.run_done);
			end else begin
				want = predicted_results.pop_front();
				if (result.status !== want.status ||
						result.dest_value !== want.dest_value ||
						result.dest_positive !== want.dest_positive ||
						result.zero_value !== want.zero_value ||
						result.zero_positive !== want.zero_positive ||
						result.run_done !== want.run_done) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: expected status %0d dest %0d/%0b zero %0d/%0b done %0b, %s",
							want.status, want.dest_value, want.dest_positive,
							want.zero_value, want.zero_positive, want.run_done,
							$sformatf("got status %0d dest %0d/%0b zero %0d/%0b done %0b",
								result.status, result.dest_value, result.dest_positive,
								result.zero_value, result.zero_positive, result.run_done));
				end
			end
		end
	end

	// Watchdog: the run is stuck if nothing is accepted and no result returns for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sign_magnitude_register_alu_unit verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus and end of run.
	initial begin
		instr_t item;
		int     sel;
		for (int i = 0; i < NUM_REGS; i++) begin
			shadow_mag[i] = '0;
			shadow_pos[i] = 1'b1;
		end

		// Directed part: field extremes, every opcode and the corner cases.
		queue_item(make_instr(OPC_MOV, 1'b0, 1'b1, 1'b1, 8'd0, 16'hFFFF, 1'b0), 1'b0);
		// Negative zero is kept as it is.
		queue_item(make_instr(OPC_MOV, 1'b0, 1'b1, 1'b0, 8'd1, 16'h0000, 1'b0), 1'b0);
		queue_item(make_instr(OPC_MOV, 1'b0, 1'b1, 1'b1, 8'd15, 16'h0001, 1'b0), 1'b0);
		queue_item(make_instr(OPC_ADD, 1'b0, 1'b0, 1'b0, 8'd2, 16'd0, 1'b0), 1'b0);
		// Product wraps modulo 2^16.
		queue_item(make_instr(OPC_MUL, 1'b0, 1'b1, 1'b0, 8'd2, 16'hFFFF, 1'b0), 1'b0);
		queue_item(make_instr(OPC_DIV, 1'b0, 1'b1, 1'b1, 8'd0, 16'd7, 1'b0), 1'b0);
		// Division by a zero immediate and by a register holding zero.
		queue_item(make_instr(OPC_DIV, 1'b0, 1'b1, 1'b1, 8'd0, 16'd0, 1'b0), 1'b0);
		queue_item(make_instr(OPC_DIV, 1'b0, 1'b0, 1'b0, 8'd3, 16'd1, 1'b0), 1'b0);
		// Subtraction that crosses zero takes the inverted second sign.
		queue_item(make_instr(OPC_SUB, 1'b0, 1'b1, 1'b1, 8'd15, 16'd5, 1'b0), 1'b0);
		// Same register as both operands.
		queue_item(make_instr(OPC_ADD, 1'b0, 1'b0, 1'b1, 8'd15, 16'd15, 1'b0), 1'b0);
		queue_item(make_instr(OPC_DEC, 1'b1, 1'b1, 1'b1, 8'd4, 16'd0, 1'b0), 1'b0);
		queue_item(make_instr(OPC_INC, 1'b0, 1'b0, 1'b0, 8'd5, 16'd0, 1'b0), 1'b0);
		queue_item(make_instr(OPC_MOV, 1'b0, 1'b1, 1'b1, 8'd6, 16'hFFFF, 1'b0), 1'b0);
		queue_item(make_instr(OPC_INC, 1'b0, 1'b1, 1'b0, 8'd6, 16'd0, 1'b0), 1'b0);
		queue_item(make_instr(OPC_MOV, 1'b0, 1'b1, 1'b0, 8'd7, 16'hFFFF, 1'b0), 1'b0);
		queue_item(make_instr(OPC_DEC, 1'b0, 1'b1, 1'b0, 8'd7, 16'd0, 1'b0), 1'b0);
		queue_item(make_instr(OPC_SSGN, 1'b0, 1'b1, 1'b1, 8'd8, 16'd0, 1'b0), 1'b0);
		queue_item(make_instr(OPC_ISGN, 1'b1, 1'b1, 1'b1, 8'd0, 16'd0, 1'b0), 1'b0);
		queue_item(make_instr(OPC_AND, 1'b0, 1'b1, 1'b1, 8'd0, 16'hAAAA, 1'b0), 1'b0);
		queue_item(make_instr(OPC_OR, 1'b0, 1'b0, 1'b0, 8'd9, 16'd0, 1'b0), 1'b0);
		queue_item(make_instr(OPC_XOR, 1'b0, 1'b1, 1'b0, 8'd0, 16'hFFFF, 1'b0), 1'b0);
		queue_item(make_instr(OPC_NOT, 1'b0, 1'b1, 1'b1, 8'd1, 16'd0, 1'b1), 1'b0);
		// Bad register indexes: destination, and a register source.
		queue_item(make_instr(OPC_ADD, 1'b1, 1'b1, 1'b1, 8'd16, 16'd3, 1'b0), 1'b0);
		queue_item(make_instr(OPC_MOV, 1'b1, 1'b1, 1'b0, 8'd255, 16'd3, 1'b0), 1'b0);
		queue_item(make_instr(OPC_MOV, 1'b0, 1'b0, 1'b1, 8'd3, 16'd16, 1'b0), 1'b0);
		queue_item(make_instr(8'd255, 1'b1, 1'b0, 1'b0, 8'd3, 16'hFFFF, 1'b1), 1'b0);
		// Unknown opcode on valid registers.
		queue_item(make_instr(8'd0, 1'b1, 1'b0, 1'b1, 8'd2, 16'd0, 1'b1), 1'b0);

		// Random part: mostly valid instructions, some noise.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sel = $urandom_range(0, 19);
			if ($urandom_range(0, 9) == 0)
				item.op = OP_W'($urandom_range(0, 255));
			else
				item.op = OP_LIST[$urandom_range(0, 12)];
			item.first_sign_bit  = 1'($urandom_range(0, 1));
			item.second_is_value = 1'($urandom_range(0, 1));
			item.second_sign_bit = 1'($urandom_range(0, 1));
			if (sel == 0)
				item.dest_reg = REG_IDX_W'($urandom_range(0, 255));
			else
				item.dest_reg = REG_IDX_W'($urandom_range(0, NUM_REGS - 1));
			if (item.second_is_value) begin
				case ($urandom_range(0, 3))
					0: item.second_field = '0;
					1: item.second_field = '1;
					2: item.second_field = MAG_W'($urandom_range(1, 16));
					default: item.second_field = MAG_W'($urandom_range(0, 65535));
				endcase
			end else if (sel == 1) begin
				item.second_field = MAG_W'($urandom_range(0, 65535));
			end else begin
				item.second_field = MAG_W'($urandom_range(0, NUM_REGS - 1));
			end
			item.end_of_run = ($urandom_range(0, 7) == 0);
			// Twice the sender waits for the block to run dry first.
			queue_item(item, (n == 0 || n == RANDOM_ITEMS / 2));
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for all items to be taken and all results to return.
		do
			@(negedge clk);
		while (pending_items.size() != 0 || start || predicted_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("sign_magnitude_register_alu_unit verification clean");
		else
			$display("sign_magnitude_register_alu_unit verification failed");
		$finish;
	end

endmodule
